### rtl/mmhc_pkg.sv
// ----------------------------------------------------------------------------
// Multiply-shift hash check package
// Shared widths, the sequencer states and the multiplier step codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mmhc_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int BYTE_W = 8;
  // Population count of a 64-bit word fits in seven bits.
  localparam int CNT_W  = 7;
  // One population-count pass per byte of the mask.
  localparam int POPC_W = 3;
  // Width of the check generation tag kept beside every slot.
  localparam int TAG_W  = 8;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_POPC,
    ST_EVAL,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_RD,
    ST_CHK
  } state_e;

  typedef enum logic [1:0] {
    STEP_LL,
    STEP_LH,
    STEP_HL
  } mul_step_e;

endpackage

`default_nettype wire

### rtl/mmhc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/mmhc_mul.sv
// ----------------------------------------------------------------------------
// Iterative 64-bit multiplier
// Forms the low 64 bits of a product from three 32x32 partial products,
// one per cycle through a single shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mmhc_mul
  import mmhc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] a_i,
  input  wire logic [WORD_W-1:0] b_i,
  output logic      [WORD_W-1:0] prod_o,
  output logic                   done_o
);

  mul_step_e         step_q, step_d;
  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [HALF_W-1:0] op_a, op_b;
  logic [WORD_W-1:0] pp;

  always_comb begin
    case (step_q)
      STEP_LL: begin
        op_a = a_i[HALF_W-1:0];
        op_b = b_i[HALF_W-1:0];
      end
      STEP_LH: begin
        op_a = a_i[HALF_W-1:0];
        op_b = b_i[WORD_W-1:HALF_W];
      end
      STEP_HL: begin
        op_a = a_i[WORD_W-1:HALF_W];
        op_b = b_i[HALF_W-1:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign pp = WORD_W'(op_a) * WORD_W'(op_b);

  always_comb begin
    step_d   = step_q;
    active_d = active_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    if (start_i) begin
      step_d   = STEP_LL;
      active_d = 1'b1;
    end else if (active_q) begin
      // Cross terms only reach the upper half of the low 64 bits.
      if (step_q == STEP_LL) begin
        acc_d = pp;
      end else begin
        acc_d = acc_q + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
      end
      case (step_q)
        STEP_LL: step_d = STEP_LH;
        STEP_LH: step_d = STEP_HL;
        STEP_HL: begin
          step_d   = STEP_LL;
          active_d = 1'b0;
          done_d   = 1'b1;
        end
        default: step_d = STEP_LL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_LL;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      step_q   <= step_d;
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### rtl/magic_multiply_hash_check_top.sv
// ----------------------------------------------------------------------------
// Multiply-shift hash collision check
// Walks the subsets of a mask, hashes each with a candidate multiplier and
// reports whether two distinct subsets share a slot.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   request  | start, busy             | occupancy_mask_i, magic_factor_i
//   result   | result_valid_o (strobe) | pass_o, mask_too_wide_o
//
// A request runs the byte-wise population count, then, for each subset, the
// three-step shared multiplier and the registered read of the slot store.
// A too wide mask gives its result once the population count is done.
// After reset, and before one check in every 255, a clearing pass over all
// 2^MAX_BITS slots rewrites the slot tags; busy stays high meanwhile.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_multiply_hash_check_top
  import mmhc_pkg::*;
#(
  parameter int MAX_BITS = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [WORD_W-1:0] occupancy_mask_i,
  input  wire logic [WORD_W-1:0] magic_factor_i,
  output logic                   result_valid_o,
  output logic                   pass_o,
  output logic                   mask_too_wide_o
);

  localparam int IDX_W = MAX_BITS;
  localparam int DEPTH = 1 << MAX_BITS;

  state_e            state_q, state_d;
  logic [WORD_W-1:0] mask_q, magic_q, pc_shift_q, subset_q;
  logic [POPC_W-1:0] pc_cnt_q;
  logic [CNT_W-1:0]  bits_q;
  logic [IDX_W-1:0]  idx_q, sweep_cnt_q;
  logic [TAG_W-1:0]  epoch_q;
  logic              pending_q;
  logic              res_valid_q, res_valid_d;
  logic              pass_q, pass_d;
  logic              wide_q, wide_d;

  logic [3:0]        byte_ones;
  logic              too_wide, epoch_full, sweep_last, collide, next_zero;
  logic [WORD_W-1:0] next_subset, mul_prod, shifted;
  logic [CNT_W-1:0]  shamt;
  logic [IDX_W-1:0]  idx_calc, tag_waddr;
  logic [TAG_W-1:0]  tag_wdata, tag_rd;
  logic [WORD_W-1:0] sub_rd;
  logic              mul_done, mul_start, slot_re, slot_we, tag_we;

  // Population count, one byte of the mask per cycle.
  always_comb begin
    byte_ones = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      byte_ones = byte_ones + 4'(pc_shift_q[i]);
    end
  end

  assign too_wide    = bits_q > CNT_W'(MAX_BITS);
  assign epoch_full  = epoch_q == '1;
  assign sweep_last  = sweep_cnt_q == '1;
  assign next_subset = (subset_q - mask_q) & mask_q;
  assign next_zero   = next_subset == '0;
  // A slot is occupied only when its tag matches the current check.
  assign collide     = (tag_rd == epoch_q) && (sub_rd != subset_q);

  assign shamt    = CNT_W'(WORD_W) - bits_q;
  assign shifted  = mul_prod >> shamt;
  assign idx_calc = (bits_q == '0) ? '0 : shifted[IDX_W-1:0];

  mmhc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (subset_q),
    .b_i     (magic_q),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP:    if (sweep_last) state_d = pending_q ? ST_MUL_GO : ST_IDLE;
      ST_IDLE:     if (start) state_d = ST_POPC;
      ST_POPC:     if (pc_cnt_q == '1) state_d = ST_EVAL;
      ST_EVAL: begin
        if (too_wide) begin
          state_d = ST_IDLE;
        end else if (epoch_full) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_MUL_GO;
        end
      end
      ST_MUL_GO:   state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: if (mul_done) state_d = ST_RD;
      ST_RD:       state_d = ST_CHK;
      ST_CHK: begin
        if (collide || next_zero) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MUL_GO;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mul_start   = 1'b0;
    slot_re     = 1'b0;
    slot_we     = 1'b0;
    tag_we      = 1'b0;
    res_valid_d = 1'b0;
    pass_d      = 1'b0;
    wide_d      = 1'b0;
    case (state_q)
      ST_SWEEP:  tag_we = 1'b1;
      ST_EVAL: begin
        res_valid_d = too_wide;
        wide_d      = too_wide;
      end
      ST_MUL_GO: mul_start = 1'b1;
      ST_RD:     slot_re = 1'b1;
      ST_CHK: begin
        slot_we     = !collide;
        tag_we      = !collide;
        res_valid_d = collide || next_zero;
        pass_d      = !collide;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign tag_waddr = (state_q == ST_SWEEP) ? sweep_cnt_q : idx_q;
  assign tag_wdata = (state_q == ST_SWEEP) ? '0 : epoch_q;

  mmhc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (slot_re),
    .raddr_i (idx_q),
    .rdata_o (tag_rd)
  );

  mmhc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_subset_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (idx_q),
    .wdata_i (subset_q),
    .re_i    (slot_re),
    .raddr_i (idx_q),
    .rdata_o (sub_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_cnt_q <= '0;
      epoch_q     <= '0;
      pending_q   <= 1'b0;
      pc_cnt_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (state_q == ST_SWEEP) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
        if (sweep_last) begin
          // Every tag is now zero, so generation one is free again.
          epoch_q   <= TAG_W'(1);
          pending_q <= 1'b0;
        end
      end
      if (state_q == ST_IDLE) begin
        pc_cnt_q <= '0;
      end else if (state_q == ST_POPC) begin
        pc_cnt_q <= pc_cnt_q + 1'b1;
      end
      if (state_q == ST_EVAL && !too_wide) begin
        if (epoch_full) begin
          pending_q <= 1'b1;
        end else begin
          epoch_q <= epoch_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    wide_q <= wide_d;
    if (state_q == ST_IDLE && start) begin
      mask_q     <= occupancy_mask_i;
      magic_q    <= magic_factor_i;
      pc_shift_q <= occupancy_mask_i;
      bits_q     <= '0;
    end
    if (state_q == ST_POPC) begin
      bits_q     <= bits_q + CNT_W'(byte_ones);
      pc_shift_q <= pc_shift_q >> BYTE_W;
    end
    if (state_q == ST_EVAL) begin
      subset_q <= '0;
    end
    if (state_q == ST_MUL_WAIT && mul_done) begin
      idx_q <= idx_calc;
    end
    if (state_q == ST_CHK && !collide) begin
      subset_q <= next_subset;
    end
  end

  assign busy            = state_q != ST_IDLE;
  assign result_valid_o  = res_valid_q;
  assign pass_o          = pass_q;
  assign mask_too_wide_o = wide_q;

`ifndef NO_ASSERTIONS
  // A request is answered by exactly one strobe, so two never abut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && mask_too_wide_o) |-> !pass_o)
    else $error("too wide mask reported as passing");

  // The generation tag in use is never the cleared value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> (epoch_q != '0))
    else $error("slot check ran with a zero generation tag");
`endif

endmodule

`default_nettype wire
